FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the profiler RTL. Empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define FPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true outside reset
`define FPT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define FPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: src/fpt_pkg.sv
// ---------------------------------------------------------------------------
// fpt_pkg
// Shared types and constants for the function profile table.
// ---------------------------------------------------------------------------
`default_nettype none

package fpt_pkg;

    // default geometry
    localparam int INDEX_BITS_DEF = 10;
    localparam int ADDR_BITS_DEF  = 32;

    // fixed field widths
    localparam int TS_W   = 64;   // timestamp and tick total
    localparam int CNT_W  = 32;   // call count and event counters
    localparam int FADR_W = 32;   // function address port
    localparam int RIDX_W = 10;   // read index port
    localparam int OP_W   = 2;

    // operation codes (code 3 behaves as a read)
    typedef enum logic [OP_W-1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WRITE
    } t_state;

endpackage

`default_nettype wire

FILE: src/function_profile_table.sv
// ---------------------------------------------------------------------------
// function_profile_table
// Direct-mapped function call profiler with per-slot count and tick total.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one event item: enter,
//   exit or slot read, with function address, timestamp and read index.
//   Output channel (o_out_valid / i_out_ready) returns one result item per
//   input item: hit and install flags, the addressed slot contents after
//   the event, and the collision and unmatched-exit counters.
//   Each item is handled from acceptance to result in order: memory read, tag
//   compare and tick difference, then the update write with the result
//   loaded into the output register. The read-modify-write of the slot
//   memory completes before the next item is accepted.
//   After reset the slot memory is swept clear, one slot per cycle, through
//   all 2^INDEX_BITS slots (1024 at default); no item is accepted meanwhile.
//   A result waiting in the output register does not block acceptance of
//   the next item; a stalled receiver holds the sequencer in its write
//   step until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module function_profile_table
    import fpt_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input items
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [FADR_W-1:0] i_func_addr,
    input  wire logic [TS_W-1:0]   i_now,
    input  wire logic [RIDX_W-1:0] i_read_index,
    // result items
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_hit,
    output logic                   o_installed,
    output logic                   o_slot_valid,
    output logic [FADR_W-1:0]      o_slot_addr,
    output logic [CNT_W-1:0]       o_slot_count,
    output logic [TS_W-1:0]        o_slot_total,
    output logic [CNT_W-1:0]       o_collisions,
    output logic [CNT_W-1:0]       o_unmatched_exits
);

    // entry layout: {used, tag, start, calls, sum}
    localparam int SUM_LO   = 0;
    localparam int CALLS_LO = SUM_LO + TS_W;
    localparam int START_LO = CALLS_LO + CNT_W;
    localparam int TAG_LO   = START_LO + TS_W;
    localparam int USED_BIT = TAG_LO + ADDR_BITS;
    localparam int ENTRY_W  = USED_BIT + 1;

    t_state r_state, n_state;

    logic                  clearing;
    logic                  in_acc;
    logic                  ld_out;
    logic                  is_event;
    logic [TS_W-1:0]       in_addr64;
    logic [ADDR_BITS-1:0]  in_tag;
    logic [TS_W-1:0]       in_tag64;
    logic [CNT_W-1:0]      rd_idx32;
    logic [INDEX_BITS-1:0] sel_idx;

    logic [ENTRY_W-1:0]    rd_data;
    logic                  wr_en;
    logic [ENTRY_W-1:0]    wr_data;

    // accepted item
    logic                  r_enter, r_exit;
    logic [ADDR_BITS-1:0]  r_tag;
    logic [TS_W-1:0]       r_now;
    logic [INDEX_BITS-1:0] r_idx;

    // compare step results
    logic                  r_hit;
    logic [TS_W-1:0]       r_diff;
    logic [ENTRY_W-1:0]    r_ent;

    // event counters
    logic [CNT_W-1:0]      r_coll, n_coll;
    logic [CNT_W-1:0]      r_miss, n_miss;

    // output register
    logic                  r_out_valid;
    logic                  r_o_hit, r_o_installed, r_o_used;
    logic [FADR_W-1:0]     r_o_addr;
    logic [CNT_W-1:0]      r_o_count;
    logic [TS_W-1:0]       r_o_total;

    // fields of the freshly read entry
    logic                  rd_used;
    logic [ADDR_BITS-1:0]  rd_tag;
    logic [TS_W-1:0]       rd_start;

    // fields of the held entry and its update
    logic                  en_used, nw_used;
    logic [ADDR_BITS-1:0]  en_tag, nw_tag;
    logic [TS_W-1:0]       en_start, nw_start;
    logic [CNT_W-1:0]      en_calls, nw_calls;
    logic [TS_W-1:0]       en_sum, nw_sum;
    logic                  installed;
    logic [TS_W-1:0]       nw_tag64;

    // input decode
    assign is_event  = (i_op == OP_ENTER) || (i_op == OP_EXIT);
    assign in_addr64 = TS_W'(i_func_addr);
    assign in_tag    = in_addr64[ADDR_BITS-1:0];
    assign in_tag64  = TS_W'(in_tag);
    assign rd_idx32  = CNT_W'(i_read_index);
    assign sel_idx   = is_event ? in_tag64[INDEX_BITS-1:0] : rd_idx32[INDEX_BITS-1:0];

    assign o_in_ready = (r_state == S_IDLE) && !clearing;
    assign in_acc     = i_in_valid && o_in_ready;

    fpt_store #(
        .INDEX_BITS (INDEX_BITS),
        .DATA_W     (ENTRY_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_acc),
        .i_rd_idx   (sel_idx),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_idx   (r_idx),
        .i_wr_data  (wr_data),
        .o_clearing (clearing)
    );

    // capture the accepted item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_enter <= (i_op == OP_ENTER);
            r_exit  <= (i_op == OP_EXIT);
            r_tag   <= in_tag;
            r_now   <= i_now;
            r_idx   <= sel_idx;
        end
    end

    // compare step: tag match and elapsed ticks
    assign rd_used  = rd_data[USED_BIT];
    assign rd_tag   = rd_data[TAG_LO +: ADDR_BITS];
    assign rd_start = rd_data[START_LO +: TS_W];

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            r_hit  <= (r_enter || r_exit) && rd_used && (rd_tag == r_tag);
            r_diff <= r_now - rd_start;
            r_ent  <= rd_data;
        end
    end

    // update step: new slot contents and counter increments
    assign en_used  = r_ent[USED_BIT];
    assign en_tag   = r_ent[TAG_LO +: ADDR_BITS];
    assign en_start = r_ent[START_LO +: TS_W];
    assign en_calls = r_ent[CALLS_LO +: CNT_W];
    assign en_sum   = r_ent[SUM_LO +: TS_W];

    assign ld_out = (r_state == S_WRITE) && (!r_out_valid || i_out_ready);

    always_comb begin
        nw_used   = en_used;
        nw_tag    = en_tag;
        nw_start  = en_start;
        nw_calls  = en_calls;
        nw_sum    = en_sum;
        installed = 1'b0;
        n_coll    = r_coll;
        n_miss    = r_miss;
        wr_en     = 1'b0;
        if (r_enter) begin
            if (r_hit) begin
                nw_start = r_now;
                nw_calls = en_calls + CNT_W'(1);
                wr_en    = ld_out;
            end else if (!en_used) begin
                nw_used   = 1'b1;
                nw_tag    = r_tag;
                nw_start  = r_now;
                nw_calls  = CNT_W'(1);
                nw_sum    = '0;
                installed = 1'b1;
                wr_en     = ld_out;
            end else begin
                n_coll = r_coll + CNT_W'(1);
            end
        end else if (r_exit) begin
            if (r_hit) begin
                nw_sum = en_sum + r_diff;
                wr_en  = ld_out;
            end else begin
                n_miss = r_miss + CNT_W'(1);
            end
        end
    end

    assign wr_data  = {nw_used, nw_tag, nw_start, nw_calls, nw_sum};
    assign nw_tag64 = TS_W'(nw_tag);

    // event counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll <= '0;
            r_miss <= '0;
        end else if (ld_out) begin
            r_coll <= n_coll;
            r_miss <= n_miss;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_o_hit       <= r_hit;
            r_o_installed <= installed;
            r_o_used      <= nw_used;
            r_o_addr      <= nw_tag64[FADR_W-1:0];
            r_o_count     <= nw_calls;
            r_o_total     <= nw_sum;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_o_hit;
    assign o_installed       = r_o_installed;
    assign o_slot_valid      = r_o_used;
    assign o_slot_addr       = r_o_addr;
    assign o_slot_count      = r_o_count;
    assign o_slot_total      = r_o_total;
    assign o_collisions      = r_coll;
    assign o_unmatched_exits = r_miss;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (ld_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks
    `FPT_ASSERT_NEVER(a_no_acc_clear, i_clk, i_rst_n, in_acc && clearing, "item accepted during clear sweep")
    `FPT_ASSERT(a_coll_stable, i_clk, i_rst_n, !(ld_out && r_enter) |=> $stable(r_coll), "collision count moved without an enter")
    `FPT_ASSERT(a_miss_stable, i_clk, i_rst_n, !(ld_out && r_exit) |=> $stable(r_miss), "unmatched count moved without an exit")
    `FPT_ASSERT_NEVER(a_hit_install, i_clk, i_rst_n, r_out_valid && r_o_hit && r_o_installed, "hit and install in one result")
    `FPT_ASSERT(a_acc_calc, i_clk, i_rst_n, in_acc |=> (r_state == S_CALC), "accepted item did not start compare")

endmodule

`default_nettype wire

FILE: src/fpt_store.sv
// ---------------------------------------------------------------------------
// fpt_store
// Slot memory: one read port with registered data, one write port, and a
// clearing sweep after reset that zeroes one entry per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module fpt_store
    import fpt_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int DATA_W     = 1 + ADDR_BITS_DEF + TS_W + CNT_W + TS_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [INDEX_BITS-1:0] i_rd_idx,
    output logic      [DATA_W-1:0]     o_rd_data,
    input  wire logic                  i_wr_en,
    input  wire logic [INDEX_BITS-1:0] i_wr_idx,
    input  wire logic [DATA_W-1:0]     i_wr_data,
    output logic                       o_clearing
);

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [DATA_W-1:0]     mem [0:DEPTH-1];
    logic [DATA_W-1:0]     r_rd_data;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic                  r_clearing;

    // clearing sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + INDEX_BITS'(1);
            if (&r_clr_idx) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // write port, shared with the sweep
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire
